/* hw/rtl/gaussian_high_pass_filter_macros.svh */
// assertion macros for the gaussian high-pass filter checker
// expects clk and rst to be visible where a macro is used
`ifndef GAUSSIAN_HIGH_PASS_FILTER_MACROS_SVH
`define GAUSSIAN_HIGH_PASS_FILTER_MACROS_SVH

// antecedent then consequent in the next cycle, off during reset
`define GHPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent in the cycle after reset
`define GHPF_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ghpf_pkg.sv */
// shared types, constants and helpers of the gaussian high-pass filter
// no dependencies
package ghpf_pkg;

  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int POS_OUT_W    = 10;
  localparam int FRAME_SIZE_W = 11;
  localparam int WEIGHT_W     = 16;
  localparam int NUM_WEIGHTS  = 6;
  localparam int CFG_W        = 16;
  localparam int IDX_W        = 3;
  localparam int KERNEL_RADIUS = 2;
  localparam int KERNEL_SPAN  = 2 * KERNEL_RADIUS + 1;
  localparam int RING_ROWS    = 16;
  localparam int RING_W       = $clog2(RING_ROWS);
  localparam int QUEUE_DEPTH  = 2;
  // 25 taps of 255 * 65535 and 25 weights of 65535
  localparam int ACC_W        = 29;
  localparam int WSUM_W       = 21;
  localparam logic [CH_W-1:0] HALF_GREY = 8'd128;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WEIGHT_CENTER = 3'd2;

  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 11'd1024;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NUM_WEIGHTS-1:0] weights_t;

  localparam weights_t WEIGHTS_RESET = {16'd783, 16'd1525, 16'd1905,
                                        16'd2971, 16'd3711, 16'd4634};

  // weight class from absolute offsets: 0, 1, 2, 4, 5, 8 squared distance
  function automatic logic [2:0] weight_index(input logic [1:0] ay, input logic [1:0] ax);
    logic [2:0] idx;
    if (ay == 2'd0 && ax == 2'd0) idx = 3'd0;
    else if ((ay == 2'd0 && ax == 2'd1) || (ay == 2'd1 && ax == 2'd0)) idx = 3'd1;
    else if (ay == 2'd1 && ax == 2'd1) idx = 3'd2;
    else if ((ay == 2'd0 && ax == 2'd2) || (ay == 2'd2 && ax == 2'd0)) idx = 3'd3;
    else if ((ay == 2'd1 && ax == 2'd2) || (ay == 2'd2 && ax == 2'd1)) idx = 3'd4;
    else idx = 3'd5;
    return idx;
  endfunction

  // distance of a kernel tap from the center row or column
  function automatic logic [1:0] tap_offset(input logic [2:0] k);
    logic [1:0] d;
    if (k >= 3'(KERNEL_RADIUS)) d = 2'(k - 3'(KERNEL_RADIUS));
    else d = 2'(3'(KERNEL_RADIUS) - k);
    return d;
  endfunction

endpackage

/* hw/rtl/ghpf_pixel_if.sv */
// input pixel channel of the gaussian high-pass filter
// depends on nothing
interface ghpf_pixel_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

/* hw/rtl/ghpf_result_if.sv */
// result pixel channel of the gaussian high-pass filter
// depends on nothing
interface ghpf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] high_red;
  logic [7:0] high_green;
  logic [7:0] high_blue;
  logic [9:0] out_column;
  logic [9:0] out_row;
  logic       frame_end;

  modport source (output valid, high_red, high_green, high_blue, out_column, out_row,
                  frame_end, input ready);
  modport sink (input valid, high_red, high_green, high_blue, out_column, out_row,
                frame_end, output ready);
endinterface

/* hw/rtl/ghpf_front.sv */
// front end: takes pixels, writes the line memory, tracks positions, issues output jobs
// depends on ghpf_pkg and ghpf_pixel_if
module ghpf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int JOB_W = RW + CW + ghpf_pkg::RING_W + 1,
  localparam int ADDR_W = ghpf_pkg::RING_W + CW
) (
  input  logic                       clk,
  input  logic                       rst,
  ghpf_pixel_if.sink                 pixel,
  input  logic                       restart,
  input  logic [WW-1:0]              width,
  input  logic [HW-1:0]              height,
  input  logic                       queue_full,
  output logic                       push,
  output logic [JOB_W-1:0]           job,
  output logic                       store_en,
  output logic [ADDR_W-1:0]          store_addr,
  output logic [ghpf_pkg::PIX_W-1:0] store_data
);
  import ghpf_pkg::*;

  typedef struct packed {
    logic [RW-1:0]     row;
    logic [CW-1:0]     col;
    logic [RING_W-1:0] phys;
    logic              last;
  } job_t;

  logic [CW-1:0]     in_col, in_col_next, out_col, out_col_next;
  logic [RW-1:0]     in_row, in_row_next, out_row, out_row_next;
  logic [RING_W-1:0] phys_in, phys_in_next, phys_out, phys_out_next;
  logic              in_full, in_full_next, full_mid, take, avail, last, accept;
  logic [WW:0]       need_c, nc, wm1;
  logic [HW:0]       need_r, nr, hm1;
  job_t              job_s;

  assign pixel.ready = !queue_full;
  assign accept      = pixel.valid && pixel.ready;
  assign take        = (pixel.opcode == OP_PIXEL) && !in_full;

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    full_mid      = in_full;
    phys_in_next  = phys_in;
    out_col_next  = out_col;
    out_row_next  = out_row;
    phys_out_next = phys_out;
    last          = 1'b0;
    if (take) begin
      if (WW'(WW'(in_col) + 1'b1) >= width) begin
        in_col_next  = '0;
        phys_in_next = phys_in + 1'b1;
        if (HW'(HW'(in_row) + 1'b1) >= height) begin
          in_row_next = '0;
          full_mid    = 1'b1;
        end else begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end
    nr     = (HW+1)'(out_row) + (HW+1)'(KERNEL_RADIUS);
    hm1    = (HW+1)'(height) - 1'b1;
    need_r = (nr > hm1) ? hm1 : nr;
    nc     = (WW+1)'(out_col) + (WW+1)'(KERNEL_RADIUS);
    wm1    = (WW+1)'(width) - 1'b1;
    need_c = (nc > wm1) ? wm1 : nc;
    avail  = full_mid || (need_r < (HW+1)'(in_row_next)) ||
             (need_r == (HW+1)'(in_row_next) && need_c < (WW+1)'(in_col_next));
    if (avail) begin
      if (WW'(WW'(out_col) + 1'b1) >= width) begin
        out_col_next  = '0;
        phys_out_next = phys_out + 1'b1;
        if (HW'(HW'(out_row) + 1'b1) >= height) begin
          out_row_next = '0;
          last         = 1'b1;
        end else begin
          out_row_next = out_row + 1'b1;
        end
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
    in_full_next = last ? 1'b0 : full_mid;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      in_full  <= 1'b0;
      phys_in  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      phys_out <= '0;
    end else if (accept) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      in_full <= in_full_next;
      phys_in <= phys_in_next;
      if (avail) begin
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        phys_out <= phys_out_next;
      end
    end
  end

  assign job_s.row  = out_row;
  assign job_s.col  = out_col;
  assign job_s.phys = phys_out;
  assign job_s.last = last;
  assign job        = job_s;
  assign push       = accept && avail;

  assign store_en   = accept && take;
  assign store_addr = {phys_in, in_col};
  assign store_data = {pixel.red_in, pixel.green_in, pixel.blue_in};
endmodule

/* hw/rtl/ghpf_queue.sv */
// short job queue between the front and back ends
// depends on ghpf_pkg
module ghpf_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import ghpf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;

  assign full     = (count == NW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end
endmodule

/* hw/rtl/ghpf_back.sv */
// back end: line memory, 5x5 weighted sum over the window, divider and result register
// depends on ghpf_pkg and ghpf_result_if
module ghpf_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int JOB_W = RW + CW + ghpf_pkg::RING_W + 1,
  localparam int ADDR_W = ghpf_pkg::RING_W + CW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  logic [JOB_W-1:0]           job,
  output logic                       pop,
  input  logic                       store_en,
  input  logic [ADDR_W-1:0]          store_addr,
  input  logic [ghpf_pkg::PIX_W-1:0] store_data,
  input  logic [WW-1:0]              width,
  input  logic [HW-1:0]              height,
  input  ghpf_pkg::weights_t         weights,
  ghpf_result_if.source              result
);
  import ghpf_pkg::*;

  typedef struct packed {
    logic [RW-1:0]     row;
    logic [CW-1:0]     col;
    logic [RING_W-1:0] phys;
    logic              last;
  } job_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [2:0] KMAX = 3'(KERNEL_SPAN - 1);
  localparam logic [2:0] KMID = 3'(KERNEL_RADIUS);
  localparam logic [2:0] DIV_LAST = 3'(CH_W - 1);

  logic [PIX_W-1:0]  mem [RING_ROWS << CW];
  logic [PIX_W-1:0]  mem_q, orig;
  logic [2:0]        state, ky, kx, step;
  job_t              cur;
  logic [RW:0]       s_row;
  logic [CW:0]       s_col;
  logic              row_in, col_in, p_en, p_center;
  logic [ADDR_W-1:0] rd_addr;
  weight_t           p_wt;
  logic [ACC_W-1:0]  acc [3];
  logic [ACC_W-1:0]  dvs;
  logic [WSUM_W-1:0] wsum;
  logic [CH_W-1:0]   quo [3];
  logic [CH_W-1:0]   blur [3];

  // window tap position and bounds
  always_comb begin
    s_row   = (RW+1)'(cur.row) + (RW+1)'(ky);
    s_col   = (CW+1)'(cur.col) + (CW+1)'(kx);
    row_in  = (s_row >= (RW+1)'(KERNEL_RADIUS)) &&
              ((s_row - (RW+1)'(KERNEL_RADIUS)) < (RW+1)'(height));
    col_in  = (s_col >= (CW+1)'(KERNEL_RADIUS)) &&
              ((s_col - (CW+1)'(KERNEL_RADIUS)) < (CW+1)'(width));
    rd_addr = {RING_W'(cur.phys + RING_W'(ky) - RING_W'(KERNEL_RADIUS)),
               CW'(s_col - (CW+1)'(KERNEL_RADIUS))};
  end

  always_ff @(posedge clk) begin
    if (store_en) mem[store_addr] <= store_data;
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  assign pop = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      p_en         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      p_en <= (state == S_READ) && row_in && col_in;
      if (result.valid && result.ready) result.valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (job_valid) state <= S_READ;
        S_READ:  if (ky == KMAX && kx == KMAX) state <= S_DRAIN;
        S_DRAIN: state <= S_LOAD;
        S_LOAD:  state <= S_DIV;
        S_DIV:   if (step == DIV_LAST) state <= S_OUT;
        S_OUT: begin
          if (!result.valid) begin
            result.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      blur[ch] = (wsum == '0) ? '0 : quo[ch];
    end
  end

  always_ff @(posedge clk) begin
    p_center <= (ky == KMID) && (kx == KMID);
    p_wt     <= weights[weight_index(tap_offset(ky), tap_offset(kx))];
    if (p_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc[ch] + ACC_W'(mem_q[PIX_W-1-CH_W*ch -: CH_W]) * ACC_W'(p_wt);
      end
      wsum <= wsum + WSUM_W'(p_wt);
      if (p_center) orig <= mem_q;
    end
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          cur  <= job_t'(job);
          ky   <= '0;
          kx   <= '0;
          wsum <= '0;
          for (int ch = 0; ch < 3; ch++) acc[ch] <= '0;
        end
      end
      S_READ: begin
        if (kx == KMAX) begin
          kx <= '0;
          ky <= ky + 1'b1;
        end else begin
          kx <= kx + 1'b1;
        end
      end
      S_LOAD: begin
        dvs  <= ACC_W'(wsum) << (CH_W - 1);
        step <= '0;
      end
      S_DIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (acc[ch] >= dvs) begin
            acc[ch] <= acc[ch] - dvs;
            quo[ch] <= {quo[ch][CH_W-2:0], 1'b1};
          end else begin
            quo[ch] <= {quo[ch][CH_W-2:0], 1'b0};
          end
        end
        dvs  <= dvs >> 1;
        step <= step + 1'b1;
      end
      S_OUT: begin
        if (!result.valid) begin
          result.high_red   <= orig[PIX_W-1 -: CH_W] - blur[0] + HALF_GREY;
          result.high_green <= orig[PIX_W-1-CH_W -: CH_W] - blur[1] + HALF_GREY;
          result.high_blue  <= orig[CH_W-1:0] - blur[2] + HALF_GREY;
          result.out_column <= POS_OUT_W'(cur.col);
          result.out_row    <= POS_OUT_W'(cur.row);
          result.frame_end  <= cur.last;
        end
      end
      default: ;
    endcase
  end
endmodule

/* hw/rtl/gaussian_high_pass_filter.sv */
// High-pass filter over a raster RGB stream: each channel is original minus a
// renormalized 5x5 Gaussian blur plus 128, wrapped to 8 bits. The front end
// takes one item per cycle while its two-entry job queue has room, storing
// pixels in a line memory of 16 rows of MAX_WIDTH pixels that needs no
// clearing after reset. For each output pixel the back end takes the job from
// the queue, makes 25 window reads through the single read port of the line
// memory, settles the sums, runs three 8-step restoring dividers side by side
// and loads the result register; it pops no new job until it has loaded the
// result, and a result left waiting holds the back end. Writing frame_width
// or frame_height restarts the frame.
module gaussian_high_pass_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  ghpf_pixel_if.sink                 pixel,
  ghpf_result_if.source              result,
  input  logic                       write_enable,
  input  logic [ghpf_pkg::IDX_W-1:0] write_index,
  input  logic [ghpf_pkg::CFG_W-1:0] write_data
);
  import ghpf_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W  = RW + CW + RING_W + 1;
  localparam int ADDR_W = RING_W + CW;

  logic [FRAME_SIZE_W-1:0] frame_width, frame_height;
  weights_t                weights;
  logic [WW-1:0]           width;
  logic [HW-1:0]           height;
  logic                    restart, push, queue_full, job_valid, pop, store_en;
  logic [JOB_W-1:0]        push_job, pop_job;
  logic [ADDR_W-1:0]       store_addr;
  logic [PIX_W-1:0]        store_data;

  assign restart = write_enable &&
                   (write_index == REG_FRAME_WIDTH || write_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_SIZE_RESET;
      frame_height <= FRAME_SIZE_RESET;
      weights      <= WEIGHTS_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_FRAME_WIDTH:  frame_width <= write_data[FRAME_SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= write_data[FRAME_SIZE_W-1:0];
        default: weights[3'(write_index - REG_WEIGHT_CENTER)] <= write_data[WEIGHT_W-1:0];
      endcase
    end
  end

  // frame size limited to 1..max
  always_comb begin
    if (frame_width == '0) width = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) width = WW'(MAX_WIDTH);
    else width = WW'(frame_width);
    if (frame_height == '0) height = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) height = HW'(MAX_HEIGHT);
    else height = HW'(frame_height);
  end

  ghpf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .restart    (restart),
    .width      (width),
    .height     (height),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job),
    .store_en   (store_en),
    .store_addr (store_addr),
    .store_data (store_data)
  );

  ghpf_queue #(.WIDTH(JOB_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (queue_full),
    .pop       (pop),
    .valid     (job_valid),
    .pop_data  (pop_job)
  );

  ghpf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (pop_job),
    .pop        (pop),
    .store_en   (store_en),
    .store_addr (store_addr),
    .store_data (store_data),
    .width      (width),
    .height     (height),
    .weights    (weights),
    .result     (result)
  );
endmodule

/* hw/rtl/ghpf_checker.sv */
// port-level checks on the result channel of the gaussian high-pass filter
// depends on gaussian_high_pass_filter_macros.svh; bound to the top level below
`include "gaussian_high_pass_filter_macros.svh"

module ghpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] high_red,
  input logic [7:0] high_green,
  input logic [7:0] high_blue,
  input logic [9:0] out_column,
  input logic [9:0] out_row,
  input logic       frame_end
);
  `GHPF_ASSERT_AFTER_RESET(a_no_result_after_reset, !result_valid, "result valid after reset")
  `GHPF_ASSERT_NEXT(a_gap_after_transfer, result_valid && result_ready, !result_valid, "result right after transfer")
  `GHPF_ASSERT_NEXT(a_valid_held, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `GHPF_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(high_red) && $stable(high_green) && $stable(high_blue) && $stable(out_column) && $stable(out_row) && $stable(frame_end), "result changed while stalled")
endmodule

bind gaussian_high_pass_filter ghpf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .high_red     (result.high_red),
  .high_green   (result.high_green),
  .high_blue    (result.high_blue),
  .out_column   (result.out_column),
  .out_row      (result.out_row),
  .frame_end    (result.frame_end)
);
